// ===== src/fmva_pkg.sv =====
// Shared types, constants and arithmetic helpers for the FM voice allocator.
`default_nettype none

package fmva_pkg;

   // voice table
   localparam int VOICES = 9;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // request kinds on the bus
   localparam logic KIND_NOTE_ON  = 1'b0;
   localparam logic KIND_NOTE_OFF = 1'b1;

   // classified commands
   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_RETUNE   = 2'd1;
   localparam logic [1:0] OP_NOTE_OFF = 2'd2;

   // chip register map
   localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
   localparam logic [7:0] ADDR_FNUM_HI = 8'hB0;
   localparam logic [7:0] KEYON_BIT    = 8'h20;

   // pitch bend
   localparam logic [6:0] BEND_CENTER = 7'd64;
   localparam int         KEYS_PER_OCT = 12;
   localparam int         DIV12_MUL    = 43;      // key*43 >> 9 == key/12 for key < 128
   localparam int         DIV12_SHIFT  = 9;
   localparam int         RECIP_63     = 16645;   // x*16645 >> 20 == x/63 for x < 8192
   localparam int         RECIP_SHIFT  = 20;

   localparam logic [9:0] FNUM_TABLE [16] = '{
      10'h134, 10'h146, 10'h15A, 10'h16E, 10'h184, 10'h19B, 10'h1B4, 10'h1CE,
      10'h1E9, 10'h206, 10'h225, 10'h246, 10'h268, 10'h28D, 10'h2B4, 10'h2DD
   };

   typedef struct packed {
      logic [1:0] op;
      logic [6:0] key;
      logic [6:0] bend;
      logic [2:0] octave;
   } cmd_type;

   function automatic logic [3:0] key_div12(input logic [6:0] key);
      logic [12:0] p;
      p = 13'(key) * 13'(DIV12_MUL);
      return p[DIV12_SHIFT+3:DIV12_SHIFT];
   endfunction

   function automatic logic [3:0] key_mod12(input logic [6:0] key);
      logic [3:0] q;
      logic [6:0] q12;
      logic [6:0] r;
      q   = key_div12(key);
      q12 = 7'(q) * 7'(KEYS_PER_OCT);
      r   = key - q12;
      return r[3:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/fmva_front.sv =====
// Front end: takes note requests, classifies them and works out the octave.
`default_nettype none

module fmva_front import fmva_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tuser,
   output      logic        cmd_valid,
   input  wire logic        cmd_ready,
   output      cmd_type     cmd
);

   logic    front_valid_ff, front_valid_in;
   cmd_type front_cmd_ff, front_cmd_in;

   logic [6:0] key;
   logic [6:0] bend;
   logic [3:0] oct_q;
   logic [3:0] oct_m1;
   logic       accept;

   assign key        = req_tdata[6:0];
   assign bend       = req_tdata[13:7];
   assign req_tready = !front_valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = front_valid_ff;
   assign cmd        = front_cmd_ff;

   always_comb begin
      oct_q  = key_div12(key);
      oct_m1 = (oct_q == 4'd0) ? 4'd0 : oct_q - 4'd1;

      front_cmd_in      = front_cmd_ff;
      front_cmd_in.key  = key;
      front_cmd_in.bend = bend;
      front_cmd_in.octave = (oct_m1 > 4'd7) ? 3'd7 : oct_m1[2:0];
      if (req_tuser == KIND_NOTE_OFF) begin
         front_cmd_in.op = OP_NOTE_OFF;
      end else if (key == 7'd0) begin
         front_cmd_in.op = OP_RETUNE;
      end else begin
         front_cmd_in.op = OP_NOTE_ON;
      end

      if (accept) begin
         front_valid_in = 1'b1;
      end else if (cmd_ready) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_cmd_ff <= front_cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fmva_queue.sv =====
// Short command queue between front and back end.
`default_nettype none

module fmva_queue import fmva_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output      logic    push_ready,
   input  wire cmd_type push_cmd,
   output      logic    pop_valid,
   input  wire logic    pop,
   output      cmd_type pop_cmd
);

   cmd_type               entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]    count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== src/fmva_back.sv =====
// Back end: voice table, F-number datapath and register write sequencer.
`default_nettype none

module fmva_back import fmva_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire cmd_type     q_cmd,
   output      logic        q_pop,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,
   output      logic        rsp_tlast
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MATCH = 4'd1;
   localparam logic [3:0] ST_PICK  = 4'd2;
   localparam logic [3:0] ST_MOD   = 4'd3;
   localparam logic [3:0] ST_LUT   = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   localparam int SCALED_W = 29;

   // voice table
   logic       voice_active_ff [VOICES];
   logic [6:0] voice_key_ff    [VOICES];
   logic [2:0] voice_octave_ff [VOICES];
   logic [9:0] voice_fnum_ff   [VOICES];

   logic [3:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [VOICES-1:0] mask_ff, mask_in;
   logic              more_ff, more_in;
   logic [VIDX_W-1:0] vidx_ff, vidx_in;
   logic [6:0]        wkey_ff, wkey_in;
   logic [3:0]        tidx_ff, tidx_in;
   logic [9:0]        f_ff, f_in;
   logic [6:0]        diff_ff, diff_in;
   logic [6:0]        delta_ff, delta_in;
   logic              up_ff, up_in;
   logic [13:0]       prod_ff, prod_in;
   logic [6:0]        q_ff, q_in;
   logic [7:0]        lo_ff, lo_in;
   logic [7:0]        hi_ff, hi_in;
   logic [1:0]        wc_ff, wc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_chip_ff, rsp_chip_in;
   logic [7:0]        rsp_addr_ff, rsp_addr_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [VOICES-1:0]   cand;
   logic [VIDX_W-1:0]   pick_idx;
   logic [VOICES-1:0]   rest;
   logic                out_free;
   logic                tbl_wr;
   logic                tbl_clr;
   logic [9:0]          fnum_new;
   logic [9:0]          neigh;
   logic [9:0]          diff_wide;
   logic [SCALED_W-1:0] scaled;
   logic [2:0]          oct_sel;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff, rsp_addr_ff, rsp_chip_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      // candidate voices for the current command
      for (int v = 0; v < VOICES; v++) begin
         case (cmd_ff.op)
            OP_NOTE_OFF: cand[v] = voice_active_ff[v] && (voice_key_ff[v] == cmd_ff.key);
            OP_RETUNE:   cand[v] = voice_active_ff[v];
            OP_NOTE_ON:  cand[v] = !voice_active_ff[v] || (voice_key_ff[v] == cmd_ff.key);
            default:     cand[v] = 1'b0;
         endcase
      end

      pick_idx = '0;
      for (int v = VOICES - 1; v >= 0; v--) begin
         if (mask_ff[v]) begin
            pick_idx = VIDX_W'(v);
         end
      end
      rest = mask_ff & (mask_ff - 1'b1);

      neigh     = up_ff ? FNUM_TABLE[tidx_ff + 4'd2] : FNUM_TABLE[tidx_ff - 4'd2];
      diff_wide = up_ff ? (neigh - f_ff) : (f_ff - neigh);
      scaled    = SCALED_W'(prod_ff) * SCALED_W'(RECIP_63);
      fnum_new  = up_ff ? (f_ff + 10'(q_ff)) : (f_ff - 10'(q_ff));
      oct_sel   = (cmd_ff.op == OP_NOTE_ON) ? cmd_ff.octave : voice_octave_ff[vidx_ff];

      state_in = state_ff;
      cmd_in   = cmd_ff;
      mask_in  = mask_ff;
      more_in  = more_ff;
      vidx_in  = vidx_ff;
      wkey_in  = wkey_ff;
      tidx_in  = tidx_ff;
      f_in     = f_ff;
      diff_in  = diff_ff;
      delta_in = delta_ff;
      up_in    = up_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      wc_in    = wc_ff;
      tbl_wr   = 1'b0;
      tbl_clr  = 1'b0;

      rsp_chip_in = rsp_chip_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            // a note-on takes only the lowest free or matching voice
            if (cmd_ff.op == OP_NOTE_ON) begin
               mask_in = cand & (~cand + 1'b1);
            end else begin
               mask_in = cand;
            end
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               vidx_in = pick_idx;
               mask_in = rest;
               more_in = (rest != '0);
               wkey_in = (cmd_ff.op == OP_NOTE_ON) ? cmd_ff.key : voice_key_ff[pick_idx];
               wc_in   = 2'd0;
               if (cmd_ff.op == OP_NOTE_OFF) begin
                  lo_in    = 8'd0;
                  hi_in    = 8'd0;
                  tbl_clr  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            tidx_in  = key_mod12(wkey_ff) + 4'd2;
            state_in = ST_LUT;
         end
         ST_LUT: begin
            f_in     = FNUM_TABLE[tidx_ff];
            up_in    = (cmd_ff.bend >= BEND_CENTER);
            delta_in = (cmd_ff.bend >= BEND_CENTER) ? (cmd_ff.bend - BEND_CENTER)
                                                    : (BEND_CENTER - cmd_ff.bend);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            diff_in  = diff_wide[6:0];
            prod_in  = 14'(delta_ff) * 14'(diff_wide[6:0]);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            q_in     = scaled[RECIP_SHIFT+6:RECIP_SHIFT];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            tbl_wr   = 1'b1;
            lo_in    = fnum_new[7:0];
            hi_in    = KEYON_BIT | {3'b0, oct_sel, 2'b00} | {6'b0, fnum_new[9:8]};
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chip_in  = wc_ff[1];
               rsp_addr_in  = wc_ff[0] ? (ADDR_FNUM_HI + 8'(vidx_ff))
                                       : (ADDR_FNUM_LO + 8'(vidx_ff));
               rsp_data_in  = wc_ff[0] ? hi_ff : lo_ff;
               rsp_last_in  = (wc_ff == 2'd3) && !more_ff;
               wc_in        = wc_ff + 2'd1;
               if (wc_ff == 2'd3) begin
                  state_in = ST_PICK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            voice_active_ff[v] <= 1'b0;
            voice_key_ff[v]    <= '0;
            voice_octave_ff[v] <= '0;
            voice_fnum_ff[v]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tbl_clr) begin
            voice_active_ff[pick_idx] <= 1'b0;
            voice_key_ff[pick_idx]    <= '0;
            voice_octave_ff[pick_idx] <= '0;
            voice_fnum_ff[pick_idx]   <= '0;
         end
         if (tbl_wr) begin
            voice_fnum_ff[vidx_ff] <= fnum_new;
            if (cmd_ff.op == OP_NOTE_ON) begin
               voice_active_ff[vidx_ff] <= 1'b1;
               voice_key_ff[vidx_ff]    <= cmd_ff.key;
               voice_octave_ff[vidx_ff] <= cmd_ff.octave;
            end
         end
      end
      cmd_ff      <= cmd_in;
      more_ff     <= more_in;
      vidx_ff     <= vidx_in;
      wkey_ff     <= wkey_in;
      tidx_ff     <= tidx_in;
      f_ff        <= f_in;
      diff_ff     <= diff_in;
      delta_ff    <= delta_in;
      up_ff       <= up_in;
      prod_ff     <= prod_in;
      q_ff        <= q_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      wc_ff       <= wc_in;
      rsp_chip_ff <= rsp_chip_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // no voices left pending once the sequencer is back to idle
   a_idle_mask_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> mask_ff == '0)
      else $error("voice mask not empty in idle");

   // a note-on never drives more than one voice
   a_note_on_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && cmd_ff.op == OP_NOTE_ON) |-> $onehot0(mask_ff))
      else $error("note-on selected several voices");

   // full bend down scales by 64/63, so the offset passes the whole tone by at most one
   a_bend_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |-> 8'(q_ff) <= 8'(diff_ff) + 8'd1)
      else $error("bend offset exceeds tone step");

   // writes only target existing voices
   a_voice_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> 32'(vidx_ff) < VOICES)
      else $error("voice index out of range");

endmodule

`default_nettype wire

// ===== src/fm_voice_allocator_top.sv =====
// Top level of the FM voice allocator: front end, command queue, back end.
// A note-on or re-tune runs each voice it touches through a voice pick, a 5-step F-number
//   datapath (mod, look-up, multiply, divide, sum) and four writes; a note-off runs each voice
//   through the pick and four writes only. A re-tune or note-off may touch all nine voices. The
//   back-end sequencer takes a new request only once back in idle, and write stalls hold it.
// The front end and a two-entry queue keep taking requests while writes drain.
// Reset (synchronous, active high) clears the voice table, the queue and all valids.
`default_nettype none

module fm_voice_allocator_top import fmva_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [6:0] key, [13:7] bend, [15:14] zero
   input  wire logic        req_tuser,   // [0] kind: 0 note-on, 1 note-off
   // register write channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // [0] chip, [8:1] reg_addr, [16:9] reg_data, rest zero
   output      logic        rsp_tlast    // final write of a request
);

   cmd_type front_cmd;
   logic    front_valid;
   logic    queue_ready;
   cmd_type queue_cmd;
   logic    queue_valid;
   logic    queue_pop;

   // classify each request and compute its octave
   fmva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (queue_ready),
      .cmd        (front_cmd)
   );

   // decouples request intake from the write sequencer
   fmva_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_cmd    (queue_cmd)
   );

   // voice allocation, F-number bend and chip write generation
   fmva_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (queue_valid),
      .q_cmd      (queue_cmd),
      .q_pop      (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
